FILE: rtl/core/blm_pkg.sv
package blm_pkg;

  // field widths
  localparam int PART_W = 8;
  localparam int BYTE_W = 8;
  localparam int NIB_W  = 4;
  localparam int LCP_W  = 9;
  localparam int SYM_W  = 3;
  localparam int RL_W   = 8;

  // partitions and nibble store sizing
  localparam int DEF_PARTITIONS = 256;
  localparam int MAX_STORE      = 2 ** PART_W;

  // symbol codes
  localparam logic [SYM_W-1:0] SYM_DOLLAR  = 3'd0;
  localparam logic [SYM_W-1:0] SYM_HASH    = 3'd5;
  localparam logic [SYM_W-1:0] SYM_INVALID = 3'd7;

  // symbols that carry a running minimum and may emit an lcp value
  localparam int NUM_MIN = 4;

  localparam logic [LCP_W-1:0] LCP_MAX     = 9'd511;
  localparam logic [RL_W-1:0]  RL_RESET    = 8'd255;

  typedef struct packed {
    logic              pass_start;
    logic [PART_W-1:0] partition;
    logic [BYTE_W-1:0] next_byte;
    logic [LCP_W-1:0]  prev_lcp;
    logic              prev_lcp_undefined;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             byte_taken;
    logic             index_valid;
    logic [LCP_W-1:0] next_index;
    logic             lcp_valid;
    logic [LCP_W-1:0] lcp_out;
    logic [LCP_W-1:0] max_lcp;
  } result_t;

  typedef struct packed {
    logic [RL_W-1:0] read_length;
  } cfg_t;

  // update of the nibble store when an item leaves the lookup stage
  typedef struct packed {
    logic              en;
    logic              clear_all;
    logic              in_range;
    logic              fill;
    logic [PART_W-1:0] addr;
    logic [NIB_W-1:0]  nib;
  } nib_upd_t;

endpackage

FILE: rtl/core/blm_stream_if.sv
interface blm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/blm_nibble_store.sv
module blm_nibble_store #(
  parameter int DEPTH = blm_pkg::DEF_PARTITIONS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [blm_pkg::PART_W-1:0] rd_addr_i,
  input  logic [blm_pkg::PART_W-1:0] look_addr_i,
  input  blm_pkg::nib_upd_t          upd_i,
  output logic                       valid_o,
  output logic [blm_pkg::NIB_W-1:0]  nib_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [blm_pkg::NIB_W-1:0] mem_q [DEPTH];
  logic [blm_pkg::NIB_W-1:0] rdata_q;
  logic [DEPTH-1:0]          valid_q;
  logic                      fwd_q;
  logic [blm_pkg::NIB_W-1:0] fwd_nib_q;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             look_addr;

  assign wr_en     = upd_i.en && upd_i.in_range && upd_i.fill;
  assign wr_addr   = upd_i.addr[AW-1:0];
  assign rd_addr   = rd_addr_i[AW-1:0];
  assign look_addr = look_addr_i[AW-1:0];

  // nibble memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= upd_i.nib;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // write in the same cycle as the read of the same entry is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_nib_q <= upd_i.nib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  // pending flags, cleared at once on reset and at pass start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i.en) begin
      for (int p = 0; p < DEPTH; p++) begin
        if (upd_i.in_range && (AW'(p) == wr_addr)) begin
          valid_q[p] <= upd_i.fill;
        end else if (upd_i.clear_all) begin
          valid_q[p] <= 1'b0;
        end
      end
    end
  end

  assign valid_o = valid_q[look_addr];
  assign nib_o   = fwd_q ? fwd_nib_q : rdata_q;

endmodule

FILE: rtl/core/bwt_lcp_merge_step.sv
// One pass step of an interleaved bwt/lcp merge.
// item_i takes one beat per partition visit: pass_start, partition, the
// partition's next packed byte and the previous pass's lcp value with its
// undefined flag. result_o gives exactly one beat per item: the decoded
// symbol, whether the byte was consumed, the routed index, the emitted lcp
// value and the largest lcp emitted since reset. cfg_i writes read_length,
// whose value plus one marks a freshly seen symbol's minimum.
// The accepting edge latches the item into the lookup stage register and
// starts the pending nibble read; from the lookup stage the block decodes
// the symbol, updates the minima, writes the nibble store back and loads
// the output register, which offers the result beat.
// Throughput is one item per cycle unless the receiver stalls; a read
// of an entry written by the item just ahead is forwarded from the write port.
// Reset empties all pending nibbles, marks all minima undefined, clears
// the largest lcp and sets read_length to 255; no clearing pass is needed.
// A pass_start beat clears minima and pending nibbles in the same cycle.
// When the receiver stalls, the output register holds its beat and the
// lookup stage holds one more item; item_i.ready drops after that.
module bwt_lcp_merge_step #(
  parameter int PARTITIONS = blm_pkg::DEF_PARTITIONS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  blm_stream_if.sink    item_i,
  blm_stream_if.sink    cfg_i,
  blm_stream_if.source  result_o
);

  localparam int STORE_DEPTH = (PARTITIONS < blm_pkg::MAX_STORE) ?
                               PARTITIONS : blm_pkg::MAX_STORE;

  blm_pkg::item_t             s1_q;
  logic                       s1_valid_q;
  logic                       s1_adv;
  logic                       in_accept;
  logic                       out_valid_q;
  blm_pkg::result_t           out_q;
  blm_pkg::result_t           out_d;
  logic [blm_pkg::RL_W-1:0]   read_length_q;
  logic [blm_pkg::LCP_W-1:0]  largest_q;
  logic [blm_pkg::LCP_W-1:0]  largest_d;
  logic [blm_pkg::NUM_MIN-1:0] def_q;
  logic [blm_pkg::NUM_MIN-1:0] def_d;
  logic [blm_pkg::LCP_W-1:0]  min_q [blm_pkg::NUM_MIN];
  logic [blm_pkg::LCP_W-1:0]  min_d [blm_pkg::NUM_MIN];
  logic [blm_pkg::LCP_W-1:0]  min_upd [blm_pkg::NUM_MIN];
  blm_pkg::nib_upd_t          upd;
  logic                       pend_valid;
  logic [blm_pkg::NIB_W-1:0]  pend_nib;
  logic                       in_range;
  logic                       use_pend;
  logic [blm_pkg::NIB_W-1:0]  code;
  logic                       known;
  logic [blm_pkg::SYM_W-1:0]  sym;
  logic                       sel_def;
  logic [blm_pkg::LCP_W-1:0]  sel_min;
  logic [blm_pkg::LCP_W:0]    lcp_sum;
  logic [blm_pkg::LCP_W-1:0]  lcp_sat;
  logic [blm_pkg::LCP_W-1:0]  rl_inf;

  // handshakes
  assign in_accept      = item_i.valid && item_i.ready;
  assign s1_adv         = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready   = !s1_valid_q || s1_adv;
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.payload = out_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_length_q <= blm_pkg::RL_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      read_length_q <= cfg_i.payload.read_length;
    end
  end

  // lookup stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= item_i.payload;
    end
  end

  // pending nibble store
  blm_nibble_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_accept),
    .rd_addr_i   (item_i.payload.partition),
    .look_addr_i (s1_q.partition),
    .upd_i       (upd),
    .valid_o     (pend_valid),
    .nib_o       (pend_nib)
  );

  // symbol decode
  always_comb begin
    in_range = 32'(s1_q.partition) < PARTITIONS;
    use_pend = in_range && !s1_q.pass_start && pend_valid;
    code     = use_pend ? pend_nib : s1_q.next_byte[7:4];
    known    = code < blm_pkg::NIB_W'(blm_pkg::SYM_HASH + 1);
    sym      = known ? code[blm_pkg::SYM_W-1:0] : blm_pkg::SYM_INVALID;

    upd.en        = s1_adv;
    upd.clear_all = s1_q.pass_start;
    upd.in_range  = in_range;
    upd.fill      = !use_pend;
    upd.addr      = s1_q.partition;
    upd.nib       = s1_q.next_byte[3:0];
  end

  // minima update, emission and write-back values
  always_comb begin
    rl_inf  = {1'b0, read_length_q} + blm_pkg::LCP_W'(1);
    sel_def = 1'b0;
    sel_min = '0;
    for (int i = 0; i < blm_pkg::NUM_MIN; i++) begin
      if (!s1_q.prev_lcp_undefined && (min_q[i] > s1_q.prev_lcp)) begin
        min_upd[i] = s1_q.prev_lcp;
      end else begin
        min_upd[i] = min_q[i];
      end
      if (sym == blm_pkg::SYM_W'(i + 1)) begin
        sel_def = def_q[i] && !s1_q.pass_start;
        sel_min = min_upd[i];
      end
      def_d[i] = (def_q[i] && !s1_q.pass_start) ||
                 (known && (sym == blm_pkg::SYM_W'(i + 1)));
      min_d[i] = (sym == blm_pkg::SYM_W'(i + 1)) ? rl_inf : min_upd[i];
    end

    lcp_sum = {1'b0, sel_min} + (blm_pkg::LCP_W + 1)'(1);
    lcp_sat = lcp_sum[blm_pkg::LCP_W] ? blm_pkg::LCP_MAX : lcp_sum[blm_pkg::LCP_W-1:0];

    largest_d = largest_q;
    if (sel_def && (lcp_sat > largest_q)) begin
      largest_d = lcp_sat;
    end

    out_d.symbol      = sym;
    out_d.byte_taken  = !use_pend;
    out_d.index_valid = known && (sym != blm_pkg::SYM_DOLLAR);
    out_d.next_index  = out_d.index_valid ?
                        ({1'b0, s1_q.partition} + blm_pkg::LCP_W'(1)) : '0;
    out_d.lcp_valid   = sel_def;
    out_d.lcp_out     = sel_def ? lcp_sat : '0;
    out_d.max_lcp     = largest_d;
  end

  // symbol minima and largest lcp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q     <= '0;
      largest_q <= '0;
    end else if (s1_adv) begin
      def_q     <= def_d;
      largest_q <= largest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int i = 0; i < blm_pkg::NUM_MIN; i++) begin
        min_q[i] <= min_d[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  // checks
  a_lcp_needs_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.lcp_valid |-> out_q.index_valid)
    else $error("lcp emitted without routed index");

  a_largest_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> largest_q >= $past(largest_q))
    else $error("largest lcp decreased");

  a_lcp_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.lcp_valid |-> out_q.lcp_out <= out_q.max_lcp)
    else $error("emitted lcp above reported maximum");

  a_advance_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced item missing from output register");

endmodule

FILE: sim/merge_step_checker.sv
module merge_step_checker
  import blm_pkg::*;
#(
  parameter int PARTITIONS = DEF_PARTITIONS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  logic    item_ready_i,
  input  item_t   item_i,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_i,
  input  cfg_t    cfg_i,
  input  logic    res_valid_i,
  input  logic    res_ready_i,
  input  result_t res_i,
  output int      err_cnt_o,
  output int      pending_o,
  output int      lcp_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYMBOLS = int'(SYM_HASH) + 1;

  // mirror of the block state
  logic             nib_held  [MAX_STORE];
  logic [NIB_W-1:0] nib_val   [MAX_STORE];
  logic             min_known [SYMBOLS];
  logic [9:0]       min_lcp   [SYMBOLS];
  logic [LCP_W-1:0] top_lcp;
  logic [RL_W-1:0]  rl;

  result_t expected_q [$];
  int      errors    = 0;
  int      lcp_beats = 0;

  assign err_cnt_o = errors;
  assign lcp_cnt_o = lcp_beats;

  // new pass: forget minima and held nibbles
  function automatic void clear_pass();
    foreach (nib_held[p]) begin
      nib_held[p] = 1'b0;
      nib_val[p]  = '0;
    end
    foreach (min_known[s]) begin
      min_known[s] = 1'b0;
      min_lcp[s]   = '0;
    end
  endfunction

  // decode one symbol, update minima and work out the result beat
  function automatic result_t merge_item(item_t it);
    result_t          r;
    logic [NIB_W-1:0] c;
    logic [9:0]       sum;
    logic             in_range;
    r = '0;
    in_range = int'(it.partition) < PARTITIONS;
    if (it.pass_start) clear_pass();

    // held low nibble first, else high nibble of the fresh byte
    if (in_range && nib_held[it.partition]) begin
      c = nib_val[it.partition];
      nib_held[it.partition] = 1'b0;
      r.byte_taken = 1'b0;
    end else begin
      c = it.next_byte[BYTE_W-1:NIB_W];
      r.byte_taken = 1'b1;
      if (in_range) begin
        nib_val[it.partition]  = it.next_byte[NIB_W-1:0];
        nib_held[it.partition] = 1'b1;
      end
    end

    // fold the previous lcp into every defined minimum except '$'
    if (!it.prev_lcp_undefined) begin
      for (int s = 1; s < SYMBOLS; s++) begin
        if (min_known[s] && min_lcp[s] > it.prev_lcp) min_lcp[s] = it.prev_lcp;
      end
    end

    if (c < SYMBOLS) begin
      r.symbol = c[SYM_W-1:0];
      if (c != SYM_DOLLAR) begin
        r.index_valid = 1'b1;
        r.next_index  = {1'b0, it.partition} + 9'd1;
      end
      if (c != SYM_DOLLAR && c != SYM_HASH && min_known[c]) begin
        sum = min_lcp[c] + 10'd1;
        if (sum > LCP_MAX) sum = LCP_MAX;
        r.lcp_valid = 1'b1;
        r.lcp_out   = sum[LCP_W-1:0];
        if (sum[LCP_W-1:0] > top_lcp) top_lcp = sum[LCP_W-1:0];
      end
      // symbol seen: its minimum restarts at infinity
      min_known[c] = 1'b1;
      min_lcp[c]   = {2'b00, rl} + 10'd1;
    end else begin
      r.symbol = SYM_INVALID;
    end
    r.max_lcp = top_lcp;
    return r;
  endfunction

  task automatic check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // follow config, item and result beats
  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      rl = RL_RESET;
      top_lcp = '0;
      clear_pass();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) rl = cfg_i.read_length;
      if (item_valid_i && item_ready_i) expected_q.push_back(merge_item(item_i));
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat arrived with nothing expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("symbol", want.symbol, res_i.symbol);
          check_field("byte_taken", want.byte_taken, res_i.byte_taken);
          check_field("index_valid", want.index_valid, res_i.index_valid);
          check_field("next_index", want.next_index, res_i.next_index);
          check_field("lcp_valid", want.lcp_valid, res_i.lcp_valid);
          check_field("lcp_out", want.lcp_out, res_i.lcp_out);
          check_field("max_lcp", want.max_lcp, res_i.max_lcp);
          if (want.lcp_valid) lcp_beats++;
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: sim/tb_bwt_lcp_merge_step.sv
module tb_bwt_lcp_merge_step;
  timeunit 1ns;
  timeprecision 1ps;

  import blm_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 305;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;

  blm_stream_if #(.payload_t(item_t))   item_if ();
  blm_stream_if #(.payload_t(cfg_t))    cfg_if ();
  blm_stream_if #(.payload_t(result_t)) res_if ();

  int              fails;
  int              in_flight;
  int              lcp_beats;
  int              items_sent = 0;
  int              holds = 0;
  bit              quiet;
  bit              hold_req;
  logic [RL_W-1:0] cur_rl = RL_RESET;

  bwt_lcp_merge_step #(.PARTITIONS(DEF_PARTITIONS)) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  merge_step_checker #(.PARTITIONS(DEF_PARTITIONS)) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .item_valid_i (item_if.valid),
    .item_ready_i (item_if.ready),
    .item_i       (item_if.payload),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_i        (cfg_if.payload),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_i        (res_if.payload),
    .err_cnt_o    (fails),
    .pending_o    (in_flight),
    .lcp_cnt_o    (lcp_beats)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #8_000_000;
    $display("tb_bwt_lcp_merge_step: done, errors");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t mk(bit ps, int part, int b, int lcp, bit undef);
    item_t it;
    it.pass_start         = ps;
    it.partition          = PART_W'(part);
    it.next_byte          = BYTE_W'(b);
    it.prev_lcp           = LCP_W'(lcp);
    it.prev_lcp_undefined = undef;
    return it;
  endfunction

  // mostly valid symbols on a few partitions, some noise
  function automatic item_t random_item();
    item_t it;
    int    r;
    it.pass_start = ($urandom_range(0, 63) == 0);
    if ($urandom_range(0, 9) < 7) it.partition = PART_W'($urandom_range(0, 7));
    else it.partition = PART_W'($urandom);
    if ($urandom_range(0, 99) < 85)
      it.next_byte = {NIB_W'($urandom_range(0, 5)), NIB_W'($urandom_range(0, 5))};
    else
      it.next_byte = BYTE_W'($urandom);
    it.prev_lcp_undefined = ($urandom_range(0, 99) < 15);
    r = $urandom_range(0, 99);
    if (r < 80) it.prev_lcp = LCP_W'($urandom_range(0, int'(cur_rl) + 1));
    else if (r < 95) it.prev_lcp = LCP_W'($urandom_range(0, 257));
    else it.prev_lcp = LCP_W'($urandom_range(0, 511));
    return it;
  endfunction

  // one item beat, valid stays high into the next item when no gap
  task automatic send_item(item_t it);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      item_if.valid <= 1'b0;
    end
    @(negedge clk);
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk); while (!item_if.ready);
    items_sent++;
  endtask

  task automatic write_read_length(logic [RL_W-1:0] v);
    @(negedge clk);
    cfg_if.valid                <= 1'b1;
    cfg_if.payload.read_length  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cur_rl = v;
  endtask

  // stop offering and let every result come back
  task automatic wait_idle();
    @(negedge clk);
    item_if.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls plus the occasional long hold
  initial begin : take_results
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
        holds++;
      end
      if (!rst_n) begin
        res_if.ready <= 1'b0;
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  initial begin : stimulus
    logic [RL_W-1:0] rl_plan [PHASES];
    item_t           first;
    rst_n          = 1'b0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    rl_plan = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd254, 8'd0};
    rl_plan[2] = RL_W'($urandom_range(3, 253));
    rl_plan[5] = RL_W'($urandom_range(3, 253));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed beats at the reset read_length
    send_item(mk(1, 0, 'h12, 0, 1));      // high nibble used, low one held
    send_item(mk(0, 0, 'hff, 5, 0));      // held nibble used, byte left alone
    send_item(mk(0, 255, 'h31, 0, 1));    // top partition
    send_item(mk(0, 1, 'h1f, 511, 0));    // lcp beyond range, symbol 1 emits
    send_item(mk(0, 1, 'h00, 0, 1));      // held nibble 15 is not a symbol
    send_item(mk(0, 2, 'h50, 300, 0));    // '#' routes an index, no lcp
    send_item(mk(0, 2, 'haa, 7, 0));      // held '$' routes nothing
    send_item(mk(0, 3, 'h6f, 0, 1));      // lowest invalid code
    send_item(mk(0, 4, 'hf0, 0, 1));      // highest invalid code
    send_item(mk(0, 5, 'h44, 0, 1));
    send_item(mk(0, 5, 'h00, 257, 0));    // minimum stays at infinity
    send_item(mk(0, 6, 'h22, 0, 0));      // minimum drops to zero
    send_item(mk(0, 7, 'h33, 511, 1));    // undefined lcp is ignored
    send_item(mk(1, 6, 'h41, 3, 0));      // new pass drops the held nibble
    send_item(mk(0, 128, 'h10, 0, 0));    // minimum undefined after the clear
    send_item(mk(0, 170, 'h3c, 'h155, 0));
    send_item(mk(0, 85, 'h5a, 'haa, 0));
    send_item(mk(0, 128, 'h00, 0, 0));
    send_item(mk(0, 6, 'h00, 100, 0));
    send_item(mk(0, 254, 'h21, 2, 0));
    send_item(mk(0, 254, 'h00, 1, 0));
    wait_idle();

    // random phases, one read_length each
    for (int ph = 0; ph < PHASES; ph++) begin
      write_read_length(rl_plan[ph]);
      quiet = (ph == 3);
      if (ph == 1 || ph == 4) hold_req = 1'b1;
      first = random_item();
      first.pass_start = 1'b1;
      send_item(first);
      for (int n = 1; n < PHASE_ITEMS; n++) send_item(random_item());
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d item beats under %0d read_length values, %0d lcp beats, %0d long holds",
             items_sent, PHASES + 1, lcp_beats, holds);
    if (fails == 0) begin
      $display("tb_bwt_lcp_merge_step: done, clean");
    end else begin
      $display("tb_bwt_lcp_merge_step: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/blm_pkg.sv
rtl/core/blm_stream_if.sv
rtl/core/blm_nibble_store.sv
rtl/core/bwt_lcp_merge_step.sv
sim/merge_step_checker.sv
sim/tb_bwt_lcp_merge_step.sv
